/* hdl/cbz_pkg.sv */
// Shared constants and types for the cubic Bezier forward-differencing tessellator.
package cbz_pkg;

	localparam int unsigned STEPS_DEF = 64;
	localparam int unsigned GUARD_DEF = 24;
	localparam int unsigned COORD_W = 24;
	localparam int unsigned ACC_W = 64;
	localparam int unsigned TOL_W = 32;
	localparam logic [TOL_W-1:0] TOL_RESET = 32'd16384;
	localparam int unsigned MAG_LIMIT_LOG2 = 30;

	// One curve as queued between the front and the back.
	typedef struct packed {
		logic signed [COORD_W-1:0] p0x;
		logic signed [COORD_W-1:0] p0y;
		logic signed [COORD_W-1:0] p1x;
		logic signed [COORD_W-1:0] p1y;
		logic signed [COORD_W-1:0] p2x;
		logic signed [COORD_W-1:0] p2y;
		logic signed [COORD_W-1:0] p3x;
		logic signed [COORD_W-1:0] p3y;
	} curve_t;

	// Handshake between the queue and the back end.
	typedef struct packed {
		logic valid;
		logic take;
	} qhs_t;

endpackage

/* hdl/cbz_queue.sv */
// Two-entry curve queue between the front end and the back end.
module cbz_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  cbz_pkg::curve_t in_curve,
	output cbz_pkg::qhs_t  hs_out,
	input  logic           out_take,
	output cbz_pkg::curve_t out_curve
);
	cbz_pkg::curve_t mem_q [2];
	logic            wr_q, rd_q;
	logic [1:0]      cnt_q;
	logic            push, pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign pop = out_take && (cnt_q != 2'd0);
	assign hs_out.valid = (cnt_q != 2'd0);
	assign hs_out.take = pop;
	assign out_curve = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_curve;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* hdl/cbz_engine.sv */
// Forward-differencing back end: loads a curve, adapts the step, emits points.
module cbz_engine #(
	parameter int unsigned STEPS = cbz_pkg::STEPS_DEF,
	parameter int unsigned GUARD_BITS = cbz_pkg::GUARD_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [cbz_pkg::TOL_W-1:0]        tol_cfg,
	input  cbz_pkg::qhs_t                    q_hs,
	output logic                             q_take,
	input  cbz_pkg::curve_t                  q_curve,
	output logic                             busy,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [cbz_pkg::COORD_W-1:0] out_x,
	output logic signed [cbz_pkg::COORD_W-1:0] out_y,
	output logic                             out_last
);
	localparam int unsigned AW = cbz_pkg::ACC_W;
	localparam int unsigned SW = $clog2(STEPS) + 2;
	localparam int unsigned TW = cbz_pkg::TOL_W + 2;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_SQ    = 7'b0000100,
		ST_SUM   = 7'b0001000,
		ST_DEC   = 7'b0010000,
		ST_STEP  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} st_t;

	st_t state_q;
	logic signed [AW-1:0] px_q, py_q, ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [SW-1:0] par_q, stp_q;
	logic [1:0]    sq_idx_q;
	logic [AW-1:0] d_q;
	logic          halving_q;
	logic          ovalid_q, olast_q;
	logic signed [cbz_pkg::COORD_W-1:0] ox_q, oy_q;

	function automatic logic signed [AW-1:0] rnd8(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] r;
		r = (v >>> GUARD_BITS) + $signed(AW'(v[GUARD_BITS-1]));
		return r;
	endfunction

	function automatic logic [cbz_pkg::MAG_LIMIT_LOG2:0] mag(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] r;
		logic [AW-1:0] m;
		r = rnd8(v);
		m = r[AW-1] ? AW'(-r) : AW'(r);
		if (m > (AW'(1) << cbz_pkg::MAG_LIMIT_LOG2)) m = AW'(1) << cbz_pkg::MAG_LIMIT_LOG2;
		return m[cbz_pkg::MAG_LIMIT_LOG2:0];
	endfunction

	function automatic logic signed [cbz_pkg::COORD_W-1:0] sat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] r;
		r = rnd8(v);
		if (r > AW'(2**(cbz_pkg::COORD_W-1) - 1))
			return {1'b0, {(cbz_pkg::COORD_W-1){1'b1}}};
		else if (r < -AW'(2**(cbz_pkg::COORD_W-1)))
			return {1'b1, {(cbz_pkg::COORD_W-1){1'b0}}};
		else
			return r[cbz_pkg::COORD_W-1:0];
	endfunction

	// Loading: basis change per axis.
	function automatic void load_ax(
		input logic signed [cbz_pkg::COORD_W-1:0] p0, p1, p2, p3,
		output logic signed [AW-1:0] pos, d1, d2, d3);
		logic signed [AW-1:0] a, b, c, e0, e1, e2, e3;
		e0 = AW'(p0); e1 = AW'(p1); e2 = AW'(p2); e3 = AW'(p3);
		a = -e0 + 3 * e1 - 3 * e2 + e3;
		b = 3 * e0 - 6 * e1 + 3 * e2;
		c = 3 * e1 - 3 * e0;
		pos = e0 <<< GUARD_BITS;
		d1 = (a + b + c) <<< GUARD_BITS;
		d2 = (6 * a + 2 * b) <<< GUARD_BITS;
		d3 = (6 * a) <<< GUARD_BITS;
	endfunction

	logic signed [AW-1:0] l_px, l_ax, l_bx, l_cx, l_py, l_ay, l_by, l_cy;
	always_comb begin
		load_ax(q_curve.p0x, q_curve.p1x, q_curve.p2x, q_curve.p3x, l_px, l_ax, l_bx, l_cx);
		load_ax(q_curve.p0y, q_curve.p1y, q_curve.p2y, q_curve.p3y, l_py, l_ay, l_by, l_cy);
	end

	// One square per cycle through a shared multiplier.
	logic [cbz_pkg::MAG_LIMIT_LOG2:0] sq_in;
	logic [AW-1:0] sq_prod;
	always_comb begin
		case (sq_idx_q)
			2'd0:    sq_in = mag(bx_q);
			2'd1:    sq_in = mag(by_q);
			2'd2:    sq_in = mag(cx_q);
			default: sq_in = mag(cy_q);
		endcase
		sq_prod = AW'(sq_in) * AW'(sq_in);
	end

	logic [TW-1:0] tol;
	logic [TW-1:0] low_lim;
	logic          too_rough, want_half, can_double;
	assign tol = {tol_cfg, 2'b00};
	assign low_lim = (tol >> 5) + TW'(tol[4:0] != 5'd0);
	assign too_rough = (d_q > AW'(tol)) && (stp_q > SW'(1));
	assign want_half = stp_q > SW'(1) &&
		(too_rough || (par_q + stp_q > SW'(STEPS)));
	assign can_double = !halving_q && (d_q != '0) && (d_q < AW'(low_lim)) &&
		(stp_q < SW'(STEPS)) && (par_q + (stp_q << 1) <= SW'(STEPS));

	// Pop the queue at the edge that loads the curve, so the loaded entry is the head.
	assign q_take = (state_q == ST_LOAD);
	assign busy = (state_q != ST_IDLE) || ovalid_q;
	assign out_valid = ovalid_q;
	assign out_x = ox_q;
	assign out_y = oy_q;
	assign out_last = olast_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				px_q <= l_px; ax_q <= l_ax; bx_q <= l_bx; cx_q <= l_cx;
				py_q <= l_py; ay_q <= l_ay; by_q <= l_by; cy_q <= l_cy;
			end
			ST_DEC: begin
				if (halving_q && want_half) begin
					ax_q <= (ax_q >>> 1) - (bx_q >>> 3) + (cx_q >>> 4);
					bx_q <= (bx_q >>> 2) - (cx_q >>> 3);
					cx_q <= cx_q >>> 3;
					ay_q <= (ay_q >>> 1) - (by_q >>> 3) + (cy_q >>> 4);
					by_q <= (by_q >>> 2) - (cy_q >>> 3);
					cy_q <= cy_q >>> 3;
				end else if (can_double) begin
					ax_q <= (ax_q <<< 1) + bx_q;
					bx_q <= (bx_q <<< 2) + (cx_q <<< 2);
					cx_q <= cx_q <<< 3;
					ay_q <= (ay_q <<< 1) + by_q;
					by_q <= (by_q <<< 2) + (cy_q <<< 2);
					cy_q <= cy_q <<< 3;
				end
			end
			ST_STEP: begin
				px_q <= px_q + ax_q; ax_q <= ax_q + bx_q; bx_q <= bx_q + cx_q;
				py_q <= py_q + ay_q; ay_q <= ay_q + by_q; by_q <= by_q + cy_q;
			end
			default: ;
		endcase
		if (state_q == ST_EMIT && !ovalid_q) begin
			ox_q <= sat(px_q);
			oy_q <= sat(py_q);
			olast_q <= (par_q >= SW'(STEPS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			par_q <= '0;
			stp_q <= SW'(STEPS);
			sq_idx_q <= '0;
			d_q <= '0;
			halving_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_hs.valid) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					par_q <= '0;
					stp_q <= SW'(STEPS);
					halving_q <= 1'b1;
					sq_idx_q <= '0;
					d_q <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					d_q <= d_q + sq_prod;
					sq_idx_q <= sq_idx_q + 2'd1;
					if (sq_idx_q == 2'd3) state_q <= ST_DEC;
				end
				ST_DEC: begin
					sq_idx_q <= '0;
					d_q <= '0;
					if (halving_q && want_half) begin
						stp_q <= stp_q >> 1;
						state_q <= ST_SQ;
					end else if (halving_q) begin
						halving_q <= 1'b0;
						d_q <= d_q;
						state_q <= ST_SUM;
					end else if (can_double) begin
						stp_q <= stp_q << 1;
						state_q <= ST_SQ;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_SUM: begin
					// re-enter the decision with the same measure, doubling phase
					state_q <= ST_DEC;
				end
				ST_STEP: begin
					par_q <= par_q + stp_q;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						if (par_q >= SW'(STEPS)) begin
							state_q <= ST_IDLE;
						end else begin
							halving_q <= 1'b1;
							sq_idx_q <= '0;
							d_q <= '0;
							state_q <= ST_SQ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* hdl/cubic_bezier_afd_tessellate.sv */
// Top level of the cubic Bezier tessellator: register, curve queue and engine.
// One curve (four 24-bit control points, 8 fraction bits) becomes up to STEPS
// line end points by adaptive forward differencing, the last one flagged by
// last_point. A small front queue holds up to two curves so a new curve beat
// is taken while the engine still works. The engine handles one curve at a
// time: a curve is first loaded, then each flatness evaluation is four
// squares through one shared multiplier, then a decision, and each point
// takes at least one evaluation, a decision that closes the halving phase,
// a sum state and a second decision, then step and emit, plus one more
// evaluation for every halving or doubling. A point also waits in emit while
// the previous point beat is still stalled. A flat curve gives a single
// point; at the finest step a curve gives STEPS points.
// Write flatness_tolerance only while no curve is in flight.
module cubic_bezier_afd_tessellate #(
	parameter int unsigned STEPS = cbz_pkg::STEPS_DEF,
	parameter int unsigned GUARD_BITS = cbz_pkg::GUARD_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [23:0] start_x,
	input  logic signed [23:0] start_y,
	input  logic signed [23:0] ctrl_one_x,
	input  logic signed [23:0] ctrl_one_y,
	input  logic signed [23:0] ctrl_two_x,
	input  logic signed [23:0] ctrl_two_y,
	input  logic signed [23:0] end_x,
	input  logic signed [23:0] end_y,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [23:0] point_x,
	output logic signed [23:0] point_y,
	output logic last_point
);
	logic [cbz_pkg::TOL_W-1:0] tol_q;
	cbz_pkg::curve_t in_curve, q_curve;
	cbz_pkg::qhs_t   q_hs;
	logic            q_take, busy;

	// Always take register beats; config is to be written only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= cbz_pkg::TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	assign in_curve = '{p0x: start_x, p0y: start_y, p1x: ctrl_one_x, p1y: ctrl_one_y,
		p2x: ctrl_two_x, p2y: ctrl_two_y, p3x: end_x, p3y: end_y};

	cbz_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_curve(in_curve), .hs_out(q_hs), .out_take(q_take), .out_curve(q_curve)
	);

	cbz_engine #(.STEPS(STEPS), .GUARD_BITS(GUARD_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .tol_cfg(tol_q), .q_hs(q_hs), .q_take(q_take),
		.q_curve(q_curve), .busy(busy), .out_valid(out_valid), .out_stall(out_stall),
		.out_x(point_x), .out_y(point_y), .out_last(last_point)
	);

	// Engine pulls a curve only when the queue holds one.
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_hs.take |-> q_hs.valid) else $error("queue popped while empty");
	// After it pulls a curve, the engine reports busy.
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |=> busy) else $error("engine not busy after taking a curve");
endmodule
